// ----- hdl/ioc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioc_pkg
// shared types and constants for the interval overlap classifier
// ----------------------------------------------------------------------------
package ioc_pkg;

  localparam int unsigned TableDepthDefault = 65536;
  localparam logic [15:0] BackWindowReset   = 16'd2048;
  localparam int unsigned ScafW  = 32;
  localparam int unsigned CoordW = 31;
  localparam int unsigned CntW   = 17;
  localparam int unsigned TotW   = 32;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  localparam logic [0:0] RegBackWindow = 1'b0;

  typedef struct packed {
    logic [ScafW-1:0]  scaffold_id;
    logic [CoordW-1:0] interval_begin;
    logic [CoordW-1:0] interval_end;
  } ival_t;

  typedef struct packed {
    logic [CntW-1:0] count_complete;
    logic [CntW-1:0] count_right;
    logic [CntW-1:0] count_left;
    logic [CntW-1:0] count_contained;
    logic            no_overlap;
    logic [TotW-1:0] total_complete;
    logic [TotW-1:0] total_right;
    logic [TotW-1:0] total_left;
    logic [TotW-1:0] total_contained;
    logic [TotW-1:0] queries_without_overlap;
  } res_t;

  // walk operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_START  = 3'd2,
    OP_READ   = 3'd3,
    OP_DEC    = 3'd4,
    OP_INC    = 3'd5,
    OP_COUNT  = 3'd6,
    OP_FINISH = 3'd7
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic empty;      // frag_count zero
    logic at_first;   // pointer at entry 0
    logic at_last;    // pointer at n-1
    logic at_end;     // pointer at n
    logic scf_gt;
    logic scf_lt;
    logic scf_eq;
    logic back_hit;   // end + window > query begin
    logic in_range;   // begin <= query end
  } stat_t;

endpackage

// ----- hdl/ioc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioc_in_if / ioc_out_if
// valid/ready channels of the classifier
// ----------------------------------------------------------------------------
interface ioc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [ioc_pkg::ScafW-1:0]   scaffold_id;
  logic [ioc_pkg::CoordW-1:0]  interval_begin;
  logic [ioc_pkg::CoordW-1:0]  interval_end;
  modport source (output valid, cmd, scaffold_id, interval_begin, interval_end,
                  input ready);
  modport sink (input valid, cmd, scaffold_id, interval_begin, interval_end,
                output ready);
endinterface

interface ioc_out_if;
  logic                      valid;
  logic                      ready;
  logic [ioc_pkg::CntW-1:0]  count_complete;
  logic [ioc_pkg::CntW-1:0]  count_right;
  logic [ioc_pkg::CntW-1:0]  count_left;
  logic [ioc_pkg::CntW-1:0]  count_contained;
  logic                      no_overlap;
  logic [ioc_pkg::TotW-1:0]  total_complete;
  logic [ioc_pkg::TotW-1:0]  total_right;
  logic [ioc_pkg::TotW-1:0]  total_left;
  logic [ioc_pkg::TotW-1:0]  total_contained;
  logic [ioc_pkg::TotW-1:0]  queries_without_overlap;
  modport source (output valid, count_complete, count_right, count_left,
                  count_contained, no_overlap, total_complete, total_right,
                  total_left, total_contained, queries_without_overlap,
                  input ready);
  modport sink (input valid, count_complete, count_right, count_left,
                count_contained, no_overlap, total_complete, total_right,
                total_left, total_contained, queries_without_overlap,
                output ready);
endinterface

// ----- hdl/ioc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioc_datapath
// fragment table, walk pointer, classifier counters and running totals
// ----------------------------------------------------------------------------
module ioc_datapath #(
  parameter int unsigned TableDepth = ioc_pkg::TableDepthDefault,
  localparam int unsigned AW = $clog2(TableDepth),
  localparam int unsigned PW = $clog2(TableDepth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ioc_pkg::cmd_t       cmd_i,
  input  ioc_pkg::ival_t      item_i,
  input  logic [15:0]         back_window_i,
  output ioc_pkg::stat_t      stat_o,
  output ioc_pkg::res_t       res_o
);

  logic [ioc_pkg::ScafW-1:0]  mem_scf [TableDepth];
  logic [ioc_pkg::CoordW-1:0] mem_beg [TableDepth];
  logic [ioc_pkg::CoordW-1:0] mem_end [TableDepth];

  logic [PW-1:0] n_q, fp_q, sp_q;
  ioc_pkg::ival_t q_q;
  logic [ioc_pkg::ScafW-1:0]  rd_scf_q;
  logic [ioc_pkg::CoordW-1:0] rd_beg_q, rd_end_q;
  // counters are as wide as the fill count, the beat carries the low bits
  logic [PW-1:0] c0_q, c1_q, c2_q, c3_q;
  logic [ioc_pkg::TotW-1:0] t0_q, t1_q, t2_q, t3_q, t4_q;
  logic [PW-1:0] nm1, fp_start;
  logic none;

  assign nm1 = n_q - PW'(1);
  assign fp_start = (sp_q > nm1) ? nm1 : sp_q;

  // memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ioc_pkg::OP_LOAD && n_q < PW'(TableDepth)) begin
      mem_scf[n_q[AW-1:0]] <= item_i.scaffold_id;
      mem_beg[n_q[AW-1:0]] <= item_i.interval_begin;
      mem_end[n_q[AW-1:0]] <= item_i.interval_end;
    end
    if (cmd_i.op == ioc_pkg::OP_READ) begin
      rd_scf_q <= mem_scf[fp_q[AW-1:0]];
      rd_beg_q <= mem_beg[fp_q[AW-1:0]];
      rd_end_q <= mem_end[fp_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ioc_pkg::OP_START) begin
      q_q <= item_i;
    end
  end

  assign none = (c0_q == '0) && (c1_q == '0) && (c2_q == '0) && (c3_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q  <= '0;
      fp_q <= '0;
      sp_q <= '0;
      c0_q <= '0;
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      t0_q <= '0;
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
      t4_q <= '0;
    end else begin
      case (cmd_i.op)
        ioc_pkg::OP_LOAD: begin
          if (n_q < PW'(TableDepth)) n_q <= n_q + PW'(1);
        end
        ioc_pkg::OP_START: begin
          fp_q <= fp_start;
          c0_q <= '0;
          c1_q <= '0;
          c2_q <= '0;
          c3_q <= '0;
        end
        ioc_pkg::OP_DEC: fp_q <= fp_q - PW'(1);
        ioc_pkg::OP_INC: fp_q <= fp_q + PW'(1);
        ioc_pkg::OP_COUNT: begin
          if (rd_beg_q < q_q.interval_begin && rd_end_q > q_q.interval_end)
            c0_q <= c0_q + PW'(1);
          else if (rd_beg_q < q_q.interval_begin && rd_end_q > q_q.interval_begin)
            c1_q <= c1_q + PW'(1);
          else if (rd_beg_q < q_q.interval_end && rd_end_q > q_q.interval_end)
            c2_q <= c2_q + PW'(1);
          else if (rd_end_q > q_q.interval_begin && rd_beg_q < q_q.interval_end)
            c3_q <= c3_q + PW'(1);
          fp_q <= fp_q + PW'(1);
        end
        ioc_pkg::OP_FINISH: begin
          if (n_q != '0) sp_q <= fp_q;
          t0_q <= t0_q + ioc_pkg::TotW'(c0_q);
          t1_q <= t1_q + ioc_pkg::TotW'(c1_q);
          t2_q <= t2_q + ioc_pkg::TotW'(c2_q);
          t3_q <= t3_q + ioc_pkg::TotW'(c3_q);
          t4_q <= t4_q + ioc_pkg::TotW'(none);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat_o.empty    = (n_q == '0);
    stat_o.at_first = (fp_q == '0);
    stat_o.at_last  = (fp_q >= nm1);
    stat_o.at_end   = (fp_q >= n_q);
    stat_o.scf_gt   = rd_scf_q > q_q.scaffold_id;
    stat_o.scf_lt   = rd_scf_q < q_q.scaffold_id;
    stat_o.scf_eq   = rd_scf_q == q_q.scaffold_id;
    stat_o.back_hit = ({1'b0, rd_end_q} + 32'(back_window_i)) > {1'b0, q_q.interval_begin};
    stat_o.in_range = rd_beg_q <= q_q.interval_end;
  end

  // counts and totals are held until the next query start
  always_comb begin
    res_o.count_complete          = ioc_pkg::CntW'(c0_q);
    res_o.count_right             = ioc_pkg::CntW'(c1_q);
    res_o.count_left              = ioc_pkg::CntW'(c2_q);
    res_o.count_contained         = ioc_pkg::CntW'(c3_q);
    res_o.no_overlap              = none;
    res_o.total_complete          = t0_q;
    res_o.total_right             = t1_q;
    res_o.total_left              = t2_q;
    res_o.total_contained         = t3_q;
    res_o.queries_without_overlap = t4_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= PW'(TableDepth))
    else $error("fill count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == ioc_pkg::OP_READ |-> fp_q < n_q)
    else $error("table read beyond fill");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == ioc_pkg::OP_FINISH && n_q != '0 |-> fp_q <= n_q)
    else $error("pointer beyond table on finish");

endmodule

// ----- hdl/ioc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioc_ctrl
// sequencer of the table walk for one query
// ----------------------------------------------------------------------------
module ioc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_cmd_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ioc_pkg::stat_t stat_i,
  output ioc_pkg::cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,  // issue read at pointer, phase in ph_q
    S_BACK  = 9'b000000100,
    S_FWD   = 9'b000001000,
    S_BWIN  = 9'b000010000,
    S_SKIP  = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  state_e ph_q, ph_d;   // phase that evaluates the next read

  always_comb begin
    state_d = state_q;
    ph_d = ph_q;
    cmd_o.op = ioc_pkg::OP_NONE;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == ioc_pkg::CMD_LOAD) begin
            cmd_o.op = ioc_pkg::OP_LOAD;
          end else begin
            cmd_o.op = ioc_pkg::OP_START;
            state_d = S_RD;
            ph_d = S_BACK;
          end
        end
      end
      S_RD: begin
        if (stat_i.empty) begin
          state_d = S_FIN;
        end else if ((ph_q == S_SKIP || ph_q == S_SCAN) && stat_i.at_end) begin
          state_d = S_FIN;
        end else begin
          cmd_o.op = ioc_pkg::OP_READ;
          state_d = ph_q;
        end
      end
      S_BACK: begin
        if (!stat_i.at_first && stat_i.scf_gt) begin
          cmd_o.op = ioc_pkg::OP_DEC;
          state_d = S_RD;
        end else begin
          state_d = S_FWD;
        end
      end
      S_FWD: begin
        if (!stat_i.at_last && stat_i.scf_lt) begin
          cmd_o.op = ioc_pkg::OP_INC;
          state_d = S_RD;
          ph_d = S_FWD;
        end else begin
          state_d = S_BWIN;
        end
      end
      S_BWIN: begin
        if (!stat_i.at_first && stat_i.scf_eq && stat_i.back_hit) begin
          cmd_o.op = ioc_pkg::OP_DEC;
          state_d = S_RD;
          ph_d = S_BWIN;
        end else begin
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        if (stat_i.scf_lt) begin
          cmd_o.op = ioc_pkg::OP_INC;
          state_d = S_RD;
          ph_d = S_SKIP;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scf_eq && stat_i.in_range) begin
          cmd_o.op = ioc_pkg::OP_COUNT;
          state_d = S_RD;
          ph_d = S_SCAN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.op = ioc_pkg::OP_FINISH;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q <= S_BACK;
    end else begin
      state_q <= state_d;
      ph_q <= ph_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |=> state_q == S_OUT)
    else $error("finish not followed by result");

endmodule

// ----- hdl/interval_overlap_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_overlap_classifier
// loads sorted fragment intervals, then counts their overlap with queries
// ----------------------------------------------------------------------------
//  channel   dir  handshake       beat
//  in_if     in   valid/ready     cmd, scaffold_id, interval_begin, interval_end
//  out_if    out  valid/ready     four counts, no_overlap, five running totals
//  apb       in   psel/penable    back_window at address 0
//
//  a load is written while idle; every pointer step of a query rereads the table
//  (seek, back-up and scan all go through the single memory read port);
//  an empty table goes straight to finish, and the scan stops at the table end
//  reset clears fill count, pointers, counts, totals; table contents stay undefined
//  one item at a time; input stalls while a result waits on out_if
// ----------------------------------------------------------------------------
module interval_overlap_classifier #(
  parameter int unsigned TableDepth = ioc_pkg::TableDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ioc_in_if.sink      in_if,
  ioc_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] back_window_q;
  ioc_pkg::cmd_t  cmd;
  ioc_pkg::stat_t stat;
  ioc_pkg::res_t  res;
  ioc_pkg::ival_t item;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_window_q <= ioc_pkg::BackWindowReset;
    end else if (psel && penable && pwrite && paddr == {ioc_pkg::RegBackWindow, 1'b0}) begin
      back_window_q <= pwdata[15:0];
    end
  end
  assign prdata = (paddr == {ioc_pkg::RegBackWindow, 1'b0}) ? {16'd0, back_window_q} : '0;

  assign item.scaffold_id    = in_if.scaffold_id;
  assign item.interval_begin = in_if.interval_begin;
  assign item.interval_end   = in_if.interval_end;

  ioc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_cmd_i    (in_if.cmd),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ioc_datapath #(.TableDepth(TableDepth)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .item_i        (item),
    .back_window_i (back_window_q),
    .stat_o        (stat),
    .res_o         (res)
  );

  assign out_if.count_complete          = res.count_complete;
  assign out_if.count_right             = res.count_right;
  assign out_if.count_left              = res.count_left;
  assign out_if.count_contained         = res.count_contained;
  assign out_if.no_overlap              = res.no_overlap;
  assign out_if.total_complete          = res.total_complete;
  assign out_if.total_right             = res.total_right;
  assign out_if.total_left              = res.total_left;
  assign out_if.total_contained         = res.total_contained;
  assign out_if.queries_without_overlap = res.queries_without_overlap;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the interval overlap classifier
// ----------------------------------------------------------------------------
// drives a short table of directed loads and queries, then sorted load and
// query bursts with some noise mixed in, under random gaps and output stalls.
// a behavioural copy of the table walk predicts each query result (the first
// directed one is typed by hand), and each result beat is compared field by
// field. back_window is changed between bursts, only while the block is idle
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned Depth = 256;
  localparam int unsigned RandomItems = 1130;
  localparam logic [ioc_pkg::CoordW-1:0] CoordMax = {ioc_pkg::CoordW{1'b1}};

  typedef struct {
    ioc_pkg::cmd_e  cmd;
    ioc_pkg::ival_t iv;
    bit             typed;
    ioc_pkg::res_t  want;
  } stim_t;

  logic clk_i;
  logic rst_ni;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  ioc_in_if  in_if ();
  ioc_out_if out_if ();

  interval_overlap_classifier #(.TableDepth(Depth)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // model of the fragment table and walk
  logic [ioc_pkg::ScafW-1:0]  frag_scf [Depth];
  logic [ioc_pkg::CoordW-1:0] frag_beg [Depth];
  logic [ioc_pkg::CoordW-1:0] frag_fin [Depth];
  int unsigned       frag_fill;
  int unsigned       walk_ptr;
  logic [ioc_pkg::TotW-1:0]   sums [5];
  logic [15:0]       window;

  ioc_pkg::res_t pending_counts [$];
  stim_t       typed_rows [$];
  int unsigned n_fail, n_queries, n_loads, n_dropped, n_nohit;

  function automatic ioc_pkg::res_t classify(input ioc_pkg::ival_t q);
    ioc_pkg::res_t r;
    int unsigned c [4];
    int unsigned fp;
    bit none;
    c = '{0, 0, 0, 0};
    if (frag_fill > 0) begin
      fp = (walk_ptr > frag_fill - 1) ? frag_fill - 1 : walk_ptr;
      while (fp > 0 && frag_scf[fp] > q.scaffold_id) fp--;
      while (fp < frag_fill - 1 && frag_scf[fp] < q.scaffold_id) fp++;
      while (fp > 0 && frag_scf[fp] == q.scaffold_id &&
             64'(frag_fin[fp]) + 64'(window) > 64'(q.interval_begin)) fp--;
      while (fp < frag_fill && frag_scf[fp] < q.scaffold_id) fp++;
      while (fp < frag_fill && frag_scf[fp] == q.scaffold_id &&
             frag_beg[fp] <= q.interval_end) begin
        if (frag_beg[fp] < q.interval_begin && frag_fin[fp] > q.interval_end) c[0]++;
        else if (frag_beg[fp] < q.interval_begin && frag_fin[fp] > q.interval_begin) c[1]++;
        else if (frag_beg[fp] < q.interval_end && frag_fin[fp] > q.interval_end) c[2]++;
        else if (frag_fin[fp] > q.interval_begin && frag_beg[fp] < q.interval_end) c[3]++;
        fp++;
      end
      walk_ptr = fp;
    end
    none = (c[0] | c[1] | c[2] | c[3]) == 0;
    for (int k = 0; k < 4; k++) sums[k] = sums[k] + c[k];
    sums[4] = sums[4] + none;
    r.count_complete  = c[0][ioc_pkg::CntW-1:0];
    r.count_right     = c[1][ioc_pkg::CntW-1:0];
    r.count_left      = c[2][ioc_pkg::CntW-1:0];
    r.count_contained = c[3][ioc_pkg::CntW-1:0];
    r.no_overlap      = none;
    r.total_complete  = sums[0];
    r.total_right     = sums[1];
    r.total_left      = sums[2];
    r.total_contained = sums[3];
    r.queries_without_overlap = sums[4];
    return r;
  endfunction

  // accepted beats on both channels
  always @(posedge clk_i) begin
    ioc_pkg::res_t r;
    logic [63:0] gotf [10];
    logic [63:0] wantf [10];
    string names [10];
    if (rst_ni && in_if.valid && in_if.ready) begin
      if (ioc_pkg::cmd_e'(in_if.cmd) == ioc_pkg::CMD_LOAD) begin
        n_loads++;
        if (frag_fill < Depth) begin
          frag_scf[frag_fill] = in_if.scaffold_id;
          frag_beg[frag_fill] = in_if.interval_begin;
          frag_fin[frag_fill] = in_if.interval_end;
          frag_fill++;
        end else begin
          n_dropped++;
        end
      end else begin
        r = classify('{in_if.scaffold_id, in_if.interval_begin, in_if.interval_end});
        if (typed_rows.size() > 0 && typed_rows[0].typed) r = typed_rows[0].want;
        if (typed_rows.size() > 0) void'(typed_rows.pop_front());
        pending_counts.push_back(r);
        n_queries++;
      end
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        n_fail++;
      end else begin
        r = pending_counts.pop_front();
        if (r.no_overlap) n_nohit++;
        names = '{"count_complete", "count_right", "count_left", "count_contained",
                  "no_overlap", "total_complete", "total_right", "total_left",
                  "total_contained", "queries_without_overlap"};
        wantf = '{r.count_complete, r.count_right, r.count_left, r.count_contained,
                  r.no_overlap, r.total_complete, r.total_right, r.total_left,
                  r.total_contained, r.queries_without_overlap};
        gotf = '{out_if.count_complete, out_if.count_right, out_if.count_left,
                 out_if.count_contained, out_if.no_overlap, out_if.total_complete,
                 out_if.total_right, out_if.total_left, out_if.total_contained,
                 out_if.queries_without_overlap};
        for (int k = 0; k < 10; k++) begin
          if (gotf[k] !== wantf[k]) begin
            $display("%0t: %s expected %0d actual %0d", $time, names[k], wantf[k], gotf[k]);
            n_fail++;
          end
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) < 3) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(10, 80)) @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send(input ioc_pkg::cmd_e c, input ioc_pkg::ival_t iv);
    int unsigned gap;
    in_if.valid          <= 1'b1;
    in_if.cmd            <= c;
    in_if.scaffold_id    <= iv.scaffold_id;
    in_if.interval_begin <= iv.interval_begin;
    in_if.interval_end   <= iv.interval_end;
    do @(posedge clk_i); while (!in_if.ready);
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) :
          ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic quiesce();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [15:0] w);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {1'b0, ioc_pkg::RegBackWindow}; pwdata <= {16'h0, w};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    window = w;
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== w) begin
      $display("%0t: back_window read expected %0d actual %0d", $time, w, prdata[15:0]);
      n_fail++;
    end
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic stim_t row(input ioc_pkg::cmd_e c, input logic [31:0] s,
                                input logic [ioc_pkg::CoordW-1:0] b,
                                input logic [ioc_pkg::CoordW-1:0] e);
    stim_t t;
    t.cmd = c;
    t.iv = '{s, b, e};
    t.typed = 1'b0;
    t.want = '0;
    return t;
  endfunction

  initial begin
    stim_t directed [$];
    stim_t t;
    logic [31:0] scf, qscf, base_scf;
    logic [ioc_pkg::CoordW-1:0] pos, qpos, base_pos, b, e;
    int unsigned sent, nl, nq;
    logic [15:0] wins [4];

    rst_ni = 1'b0;
    in_if.valid = 1'b0; in_if.cmd = ioc_pkg::CMD_LOAD;
    in_if.scaffold_id = '0; in_if.interval_begin = '0; in_if.interval_end = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    frag_fill = 0; walk_ptr = 0; sums = '{0, 0, 0, 0, 0};
    window = ioc_pkg::BackWindowReset;
    n_fail = 0; n_queries = 0; n_loads = 0; n_dropped = 0; n_nohit = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: nothing counted, one query without overlap
    t = row(ioc_pkg::CMD_QUERY, 32'd5, 31'd0, 31'd10);
    t.typed = 1'b1;
    t.want = '0;
    t.want.no_overlap = 1'b1;
    t.want.queries_without_overlap = 32'd1;
    directed.push_back(t);
    directed.push_back(row(ioc_pkg::CMD_LOAD, 32'd5, 31'd100, 31'd200));
    directed.push_back(row(ioc_pkg::CMD_LOAD, 32'd5, 31'd150, 31'd1000));
    directed.push_back(row(ioc_pkg::CMD_LOAD, 32'd5, 31'd300, 31'd400));
    directed.push_back(row(ioc_pkg::CMD_LOAD, 32'd5, 31'd500, 31'd600));
    directed.push_back(row(ioc_pkg::CMD_LOAD, 32'd7, 31'd0, CoordMax));
    directed.push_back(row(ioc_pkg::CMD_LOAD, 32'hFFFF_FFFF, CoordMax, CoordMax));
    directed.push_back(row(ioc_pkg::CMD_QUERY, 32'd0, 31'd0, 31'd10));
    directed.push_back(row(ioc_pkg::CMD_QUERY, 32'd5, 31'd160, 31'd900));
    directed.push_back(row(ioc_pkg::CMD_QUERY, 32'd5, 31'd250, 31'd350));
    directed.push_back(row(ioc_pkg::CMD_QUERY, 32'd5, 31'd50, 31'd2000));
    directed.push_back(row(ioc_pkg::CMD_QUERY, 32'd6, 31'd0, 31'd5));
    directed.push_back(row(ioc_pkg::CMD_QUERY, 32'd7, 31'd1, CoordMax));
    directed.push_back(row(ioc_pkg::CMD_QUERY, 32'hFFFF_FFFF, 31'd0, CoordMax));
    directed.push_back(row(ioc_pkg::CMD_QUERY, 32'hFFFF_FFFF, CoordMax, CoordMax));
    // walk back from the table end, then out of order
    directed.push_back(row(ioc_pkg::CMD_QUERY, 32'd5, 31'd0, 31'd100));
    directed.push_back(row(ioc_pkg::CMD_LOAD, 32'hFFFF_FFFF, CoordMax, CoordMax));
    directed.push_back(row(ioc_pkg::CMD_QUERY, 32'hFFFF_FFFF, 31'd0, CoordMax));
    directed.push_back(row(ioc_pkg::CMD_QUERY, 32'd5, 31'd120, 31'd180));

    foreach (directed[i]) begin
      if (directed[i].cmd == ioc_pkg::CMD_QUERY) typed_rows.push_back(directed[i]);
    end
    foreach (directed[i]) send(directed[i].cmd, directed[i].iv);
    quiesce();

    wins = '{16'd0, 16'hFFFF, ioc_pkg::BackWindowReset, 16'd300};
    scf = 32'd10;
    pos = '0;
    sent = 0;
    while (sent < RandomItems) begin
      if ($urandom_range(0, 3) == 0) begin
        quiesce();
        set_window(($urandom_range(0, 2) == 0) ? 16'($urandom) : wins[$urandom_range(0, 3)]);
      end
      base_scf = scf;
      base_pos = pos;
      nl = $urandom_range(1, 20);
      for (int i = 0; i < nl; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send(ioc_pkg::CMD_LOAD,
               '{$urandom, ioc_pkg::CoordW'($urandom), ioc_pkg::CoordW'($urandom)});
        end else begin
          if ($urandom_range(0, 5) == 0) begin
            scf = scf + $urandom_range(1, 2);
            pos = ioc_pkg::CoordW'($urandom_range(0, 500));
          end
          b = ioc_pkg::CoordW'(pos + $urandom_range(0, 300));
          e = ioc_pkg::CoordW'(b + $urandom_range(0, 3000));
          pos = b;
          send(ioc_pkg::CMD_LOAD, '{scf, b, e});
        end
        sent++;
      end
      qscf = base_scf;
      qpos = base_pos;
      nq = $urandom_range(1, 30);
      for (int i = 0; i < nq; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send(ioc_pkg::CMD_QUERY,
               '{$urandom, ioc_pkg::CoordW'($urandom), ioc_pkg::CoordW'($urandom)});
        end else begin
          if ($urandom_range(0, 4) == 0 && qscf <= scf) begin
            qscf = qscf + 32'd1;
            qpos = ioc_pkg::CoordW'($urandom_range(0, 500));
          end
          b = ioc_pkg::CoordW'(qpos + $urandom_range(0, 400));
          e = ioc_pkg::CoordW'(b + $urandom_range(0, 2500));
          qpos = b;
          send(ioc_pkg::CMD_QUERY, '{qscf, b, e});
        end
        sent++;
      end
      // let every expected result drain before the next burst now and then
      if ($urandom_range(0, 4) == 0) quiesce();
      scf = scf + $urandom_range(1, 3);
      pos = ioc_pkg::CoordW'($urandom_range(0, 500));
    end
    quiesce();
    set_window(16'hFFFF);

    in_if.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (Depth * 2 + 50) @(posedge clk_i);
    $display("loads %0d (dropped on full table %0d), queries %0d, queries without overlap %0d",
             n_loads, n_dropped, n_queries, n_nohit);
    if (n_fail == 0 && pending_counts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("FAILURE");
    $finish;
  end

endmodule
